// ----- rtl/core/mono_plasma_cga_display_controller_unit_macros.svh -----
// Assertion macros used by the checker file of the display controller.
`ifndef MONO_PLASMA_CGA_DISPLAY_CONTROLLER_UNIT_MACROS_SVH
`define MONO_PLASMA_CGA_DISPLAY_CONTROLLER_UNIT_MACROS_SVH

// Implication checked at the same clock edge.
`define MPCGA_ASSERT_SAME(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("mpcga assertion failed");

// Implication checked at the following clock edge.
`define MPCGA_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("mpcga assertion failed");

// Implication checked at the following edge, also while reset is applied.
`define MPCGA_ASSERT_NEXT_ALWAYS(label, clk, cond, prop) \
  label: assert property (@(posedge clk) (cond) |=> (prop)) \
    else $error("mpcga assertion failed");

`endif

// ----- rtl/core/mpcga_pkg.sv -----
// ----------------------------------------------------------------------------
// mpcga_pkg
// Types and constants of the two-colour CGA-compatible display controller.
// ----------------------------------------------------------------------------
package mpcga_pkg;

  typedef enum logic [2:0] {
    OP_MEM_WRITE  = 3'd0,
    OP_MEM_READ   = 3'd1,
    OP_PORT_WRITE = 3'd2,
    OP_PORT_READ  = 3'd3,
    OP_FONT_WRITE = 3'd4,
    OP_CELL_TICK  = 3'd5,
    OP_UNUSED_6   = 3'd6,
    OP_UNUSED_7   = 3'd7
  } op_t;

  localparam logic KIND_PIXELS = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  localparam logic [14:0] PORT_CRTC_LAST = 15'd7;
  localparam logic [14:0] PORT_CONTROL   = 15'd8;
  localparam logic [14:0] PORT_COLOUR    = 15'd9;
  localparam logic [14:0] PORT_STATUS    = 15'd10;

  localparam logic [7:0] STATUS_RESET = 8'hF4;
  localparam logic [7:0] UNMAPPED     = 8'hFF;
  localparam logic [6:0] LAST_GROUP   = 7'd79;

  localparam int CRTC_MAX_SCAN   = 9;
  localparam int CRTC_CUR_START  = 10;
  localparam int CRTC_CUR_END    = 11;
  localparam int CRTC_START_HI   = 12;
  localparam int CRTC_START_LO   = 13;
  localparam int CRTC_CURSOR_HI  = 14;
  localparam int CRTC_CURSOR_LO  = 15;

endpackage

// ----- rtl/core/mpcga_ram.sv -----
// ----------------------------------------------------------------------------
// mpcga_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mpcga_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/mono_plasma_cga_display_controller_unit.sv -----
// ----------------------------------------------------------------------------
// mono_plasma_cga_display_controller_unit
// CGA-compatible controller for a 640x400 two-colour plasma panel.
// ----------------------------------------------------------------------------
// The block accepts one transaction per clock while the result register is
// free or being drained; a result passes through stage one, stage two and the
// output register, set by the chain of a video memory read followed by a
// dependent font memory read. Video memory is held twice so that character
// and attribute bytes are read in the same cycle. There is no clearing pass after reset.
module mono_plasma_cga_display_controller_unit #(
  parameter int VRAM_BYTES   = 32768,
  parameter int ACTIVE_LINES = 400,
  parameter int TOTAL_LINES  = 416
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // opcode[2:0], address[17:3], write_data[25:18], zero fill
  input  logic [31:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // read_data[7:0], pixels[15:8], line[24:16], group[31:25]
  output logic [31:0] m_axis_tdata,
  output logic        m_axis_tlast,
  // kind[0]
  output logic        m_axis_tuser
);
  import mpcga_pkg::*;

  localparam int VA_W = $clog2(VRAM_BYTES);

  function automatic logic [VA_W-1:0] vmod(input logic [14:0] a);
    logic [15:0] t;
    t = ({1'b0, a} >= 16'(VRAM_BYTES)) ? {1'b0, a} - 16'(VRAM_BYTES) : {1'b0, a};
    return t[VA_W-1:0];
  endfunction

  logic [3:0]  option_reg;
  logic [7:0]  crtc [32];
  logic [4:0]  crtc_index;
  logic [7:0]  control_reg, colour_reg, status_reg;
  logic [8:0]  line_count;
  logic [6:0]  cell_count;
  logic        display_on;
  logic [4:0]  blink_count;

  op_t         op;
  logic [14:0] addr;
  logic [7:0]  wdata;
  logic        adv, acc, tick;

  assign op    = op_t'(s_axis_tdata[2:0]);
  assign addr  = s_axis_tdata[17:3];
  assign wdata = s_axis_tdata[25:18];
  assign adv   = !m_axis_tvalid || m_axis_tready;
  assign acc   = s_axis_tvalid && adv;
  assign tick  = acc && (op == OP_CELL_TICK);
  assign s_axis_tready = adv;

  // Address generation and cursor decode for the cell being ticked, and port read decode.
  logic [14:0] ma, ca;
  logic        wide;
  logic [6:0]  cols, ch;
  logic [11:0] rowcols;
  logic [15:0] tma;
  logic [16:0] chr_sum;
  logic [14:0] chr_a, attr_a, gfx_a;
  logic [16:0] gfx_sum;
  logic [14:0] bank;
  logic [15:0] cur_sum;
  logic [4:0]  sc2s, sc2e;
  logic        curline, cursor;
  logic        gfx;
  logic [7:0]  port_val;

  always_comb begin
    ma      = {crtc[CRTC_START_HI][6:0], crtc[CRTC_START_LO]};
    ca      = {crtc[CRTC_CURSOR_HI][6:0], crtc[CRTC_CURSOR_LO]};
    wide    = !control_reg[0];
    cols    = wide ? 7'd40 : 7'd80;
    ch      = wide ? {1'b0, cell_count[6:1]} : cell_count;
    rowcols = {7'd0, line_count[8:4]} * {5'd0, cols};
    tma     = {1'b0, ma[14:1], 1'b0} + {4'd0, rowcols};
    chr_sum = {tma, 1'b0} + {9'd0, ch, 1'b0};
    chr_a   = chr_sum[14:0];
    attr_a  = {chr_a[14:1], 1'b1};
    cur_sum = {1'b0, ma} + {4'd0, rowcols} + {9'd0, ch};
    sc2s    = {crtc[CRTC_CUR_START][3:0], 1'b0};
    sc2e    = {crtc[CRTC_CUR_END][3:0], 1'b0};
    curline = (crtc[CRTC_CUR_START][6:5] != 2'b01) &&
              (sc2s <= {1'b0, line_count[3:0]}) && (sc2e >= {1'b0, line_count[3:0]});
    cursor  = (cur_sum == {1'b0, ca}) && curline && control_reg[3] && blink_count[4];
    gfx     = control_reg[1];
    if (crtc[CRTC_MAX_SCAN] == 8'd3) begin
      bank = {line_count[1], line_count[0], 13'd0};
    end else begin
      bank = {1'b0, line_count[1], 13'd0};
    end
    gfx_sum = {2'b0, bank} + {3'd0, {7'd0, line_count[8:2]} * 14'd80} +
              {1'b0, ma[14:1], 2'b0} + {10'd0, cell_count};
    gfx_a   = gfx_sum[14:0];
    if (addr <= PORT_CRTC_LAST) begin
      port_val = addr[0] ? crtc[crtc_index] : {3'd0, crtc_index};
    end else if (addr == PORT_CONTROL) begin
      port_val = control_reg;
    end else if (addr == PORT_COLOUR) begin
      port_val = colour_reg;
    end else if (addr == PORT_STATUS) begin
      port_val = status_reg;
    end else begin
      port_val = UNMAPPED;
    end
  end

  // Video memory, held as two copies for the two read addresses.
  logic [14:0] vra_a;
  logic [7:0]  qa, qb;
  logic        vwe;

  assign vwe   = acc && (op == OP_MEM_WRITE) && !option_reg[3];
  assign vra_a = (op == OP_CELL_TICK) ? (gfx ? gfx_a : chr_a) : addr;

  mpcga_ram #(.WIDTH(8), .DEPTH(VRAM_BYTES)) u_vram_a (
    .clk(clk), .we(vwe), .waddr(vmod(addr)), .wdata(wdata),
    .re(adv), .raddr(vmod(vra_a)), .rdata(qa)
  );

  mpcga_ram #(.WIDTH(8), .DEPTH(VRAM_BYTES)) u_vram_b (
    .clk(clk), .we(vwe), .waddr(vmod(addr)), .wdata(wdata),
    .re(adv), .raddr(vmod(attr_a)), .rdata(qb)
  );

  // Stage one: video data arrives.
  logic       v1, kind1, usevram1, gfx1, wide1, cursor1, bmode1, bon1, thin1;
  logic       gen1, gmono1, gcol1;
  logic [7:0] pv1;
  logic [8:0] ln1;
  logic [6:0] grp1;
  logic       last1;

  // Stage two: font data arrives.
  logic       v2, kind2, gfx2, wide2, cursor2, fg2, bg2;
  logic [7:0] rd2, gpix2;
  logic [8:0] ln2;
  logic [6:0] grp2;
  logic       last2;

  logic [8:0]  glyph;
  logic        fg1, bg1, blinking1, zero1;
  logic [7:0]  gpix1, fq;

  always_comb begin
    glyph     = {(thin1 ? qb[3] : !qb[3]), qa};
    blinking1 = bon1 && bmode1 && qb[7] && !cursor1;
    fg1       = (qb[6:4] == 3'd0);
    bg1       = !fg1;
    zero1     = bmode1 ? ({1'b0, qb[6:4]} == qb[3:0]) : (qb[7:4] == qb[3:0]);
    if (zero1) begin
      fg1 = 1'b0;
      bg1 = 1'b0;
    end
    if (bmode1 && blinking1) begin
      fg1 = bg1;
    end
    gpix1 = 8'd0;
    if (!gen1) begin
      gpix1 = 8'd0;
    end else if (gmono1) begin
      gpix1 = gcol1 ? qa : 8'd0;
    end else begin
      for (int c = 0; c < 4; c++) begin
        unique case (qa[2*c +: 2])
          2'd0: gpix1[2*c +: 2] = 2'd0;
          2'd3: gpix1[2*c +: 2] = 2'd3;
          2'd2: gpix1[2*c +: 2] = ln1[0] ? 2'd1 : 2'd2;
          default: gpix1[2*c +: 2] = ln1[0] ? 2'd0 : 2'd2;
        endcase
      end
    end
  end

  mpcga_ram #(.WIDTH(8), .DEPTH(8192)) u_font (
    .clk(clk), .we(acc && (op == OP_FONT_WRITE)), .waddr(addr[12:0]), .wdata(wdata),
    .re(adv), .raddr({glyph, ln1[3:0]}), .rdata(fq)
  );

  logic [3:0] nib;
  logic [7:0] font, tpix;

  always_comb begin
    nib  = grp2[0] ? fq[3:0] : fq[7:4];
    font = fq;
    if (wide2) begin
      for (int i = 0; i < 4; i++) begin
        font[2*i +: 2] = {2{nib[i]}};
      end
    end
    tpix = (font & {8{fg2}}) | (~font & {8{bg2}});
    if (cursor2) begin
      tpix = ~tpix;
    end
  end

  // Pipeline and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      v1 <= acc && (op == OP_MEM_READ || op == OP_PORT_READ || (tick && display_on));
      v2 <= v1;
      m_axis_tvalid <= v2;
    end
    if (adv) begin
      kind1    <= (op == OP_CELL_TICK) ? KIND_PIXELS : KIND_READ;
      usevram1 <= (op == OP_MEM_READ) && !option_reg[3];
      pv1      <= (op == OP_PORT_READ) ? port_val : UNMAPPED;
      gfx1     <= gfx;
      wide1    <= wide;
      cursor1  <= cursor;
      bmode1   <= control_reg[5];
      bon1     <= blink_count[4];
      thin1    <= option_reg[2];
      gen1     <= control_reg[3];
      gmono1   <= control_reg[4];
      gcol1    <= (colour_reg[3:0] != 4'd0);
      ln1      <= line_count;
      grp1     <= cell_count;
      last1    <= (cell_count >= LAST_GROUP);

      kind2   <= kind1;
      rd2     <= (kind1 == KIND_READ) ? (usevram1 ? qa : pv1) : 8'd0;
      gfx2    <= gfx1;
      gpix2   <= gpix1;
      wide2   <= wide1;
      cursor2 <= cursor1;
      fg2     <= fg1;
      bg2     <= bg1;
      ln2     <= ln1;
      grp2    <= grp1;
      last2   <= last1;

      m_axis_tuser <= kind2;
      if (kind2 == KIND_READ) begin
        m_axis_tdata <= {24'd0, rd2};
        m_axis_tlast <= 1'b0;
      end else begin
        m_axis_tdata <= {grp2, ln2, (gfx2 ? gpix2 : tpix), 8'd0};
        m_axis_tlast <= last2;
      end
    end
  end

  // Register file and timing counters.
  logic [8:0] ln_next;
  logic [7:0] status_next;
  logic [8:0] line_next;
  logic [6:0] cell_next;
  logic       disp_next;
  logic [4:0] blink_next;

  always_comb begin
    ln_next     = line_count + 9'd1;
    status_next = status_reg;
    line_next   = line_count;
    cell_next   = cell_count;
    disp_next   = display_on;
    blink_next  = blink_count;
    if (tick) begin
      if (cell_count == 7'd0 && display_on) begin
        status_next[0] = 1'b0;
      end
      if (cell_count >= LAST_GROUP) begin
        cell_next      = 7'd0;
        status_next[0] = 1'b1;
        line_next      = ln_next;
        if (ln_next == 9'(ACTIVE_LINES)) begin
          status_next[3] = 1'b1;
          disp_next      = 1'b0;
          blink_next     = blink_count + 5'd1;
        end
        if (ln_next == 9'(TOTAL_LINES % 512)) begin
          line_next      = 9'd0;
          status_next[3] = 1'b0;
          disp_next      = 1'b1;
        end
      end else begin
        cell_next = cell_count + 7'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      option_reg <= 4'd0;
      for (int r = 0; r < 32; r++) begin
        crtc[r] <= 8'd0;
      end
      crtc_index  <= 5'd0;
      control_reg <= 8'd0;
      colour_reg  <= 8'd0;
      status_reg  <= STATUS_RESET;
      line_count  <= 9'd0;
      cell_count  <= 7'd0;
      display_on  <= 1'b0;
      blink_count <= 5'd0;
    end else begin
      if (cfg_we) begin
        option_reg <= cfg_wdata;
      end
      if (acc && op == OP_PORT_WRITE) begin
        if (addr <= PORT_CRTC_LAST) begin
          if (addr[0]) begin
            crtc[crtc_index] <= wdata;
          end else begin
            crtc_index <= wdata[4:0];
          end
        end else if (addr == PORT_CONTROL) begin
          control_reg <= wdata;
        end else if (addr == PORT_COLOUR) begin
          colour_reg <= wdata;
        end
      end
      status_reg  <= status_next;
      line_count  <= line_next;
      cell_count  <= cell_next;
      display_on  <= disp_next;
      blink_count <= blink_next;
    end
  end

endmodule

// ----- rtl/core/mpcga_checker.sv -----
// ----------------------------------------------------------------------------
// mpcga_checker
// Port-level checks of the display controller's result stream.
// ----------------------------------------------------------------------------
`include "mono_plasma_cga_display_controller_unit_macros.svh"

module mpcga_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        m_axis_tuser
);
  import mpcga_pkg::*;

  `MPCGA_ASSERT_NEXT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `MPCGA_ASSERT_NEXT_ALWAYS(a_reset_idle, clk, rst, !m_axis_tvalid)
  `MPCGA_ASSERT_SAME(a_pixel_fields, clk, rst, m_axis_tvalid && m_axis_tuser == KIND_PIXELS, (m_axis_tdata[7:0] == 8'd0) && (m_axis_tdata[31:25] <= LAST_GROUP) && (m_axis_tlast == (m_axis_tdata[31:25] == LAST_GROUP)))
  `MPCGA_ASSERT_SAME(a_read_fields, clk, rst, m_axis_tvalid && m_axis_tuser == KIND_READ, (m_axis_tdata[31:8] == 24'd0) && !m_axis_tlast)

endmodule

bind mono_plasma_cga_display_controller_unit mpcga_checker u_mpcga_checker (
  .clk(clk), .rst(rst), .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast), .m_axis_tuser(m_axis_tuser)
);
